// ===== sv/pib_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the palette index builder.
// No dependencies; every other file imports this package.
package pib_pkg;

   localparam int ColorWidth   = 32;
   localparam int IndexWidth   = 8;
   localparam int CountWidth   = 9;
   localparam int QueueDepth   = 2;
   localparam int QueuePtrBits = 1;
   localparam int QueueFillBits = 2;

   typedef struct packed {
      logic [ColorWidth-1:0] pixel_color;
      logic                  last_pixel;
   } pib_req_type;

   typedef struct packed {
      logic [IndexWidth-1:0] color_index;
      logic                  is_new_color;
      logic                  palette_overflow;
      logic [CountWidth-1:0] color_count;
      logic                  image_done;
   } pib_rsp_type;

   // Item as it travels from the front stage to the search engine.
   typedef struct packed {
      logic [ColorWidth-1:0] color;
      logic                  last;
   } pib_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } pib_state_type;

endpackage

// ===== sv/pib_front.sv =====
`timescale 1ns / 1ps
// Front stage: accepts pixels, masks the color to the compared width.
// Depends on pib_pkg.
module pib_front #(
   parameter int PIXEL_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pib_pkg::pib_req_type req_data,
   output logic                 push_valid,
   input  logic                 push_ready,
   output pib_pkg::pib_item_type push_data
);
   import pib_pkg::*;

   localparam logic [ColorWidth-1:0] PixelMask =
      (PIXEL_BITS >= ColorWidth) ? {ColorWidth{1'b1}}
                                 : ColorWidth'((64'd1 << PIXEL_BITS) - 64'd1);

   logic         hold_valid_ff;
   logic         hold_valid_in;
   pib_item_type hold_ff;
   pib_item_type hold_in;
   logic         accept;

   assign req_ready  = !hold_valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = hold_valid_ff;
   assign push_data  = hold_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_in.color = req_data.pixel_color & PixelMask;
         hold_in.last  = req_data.last_pixel;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

endmodule

// ===== sv/pib_queue.sv =====
`timescale 1ns / 1ps
// Two-entry item queue between the front stage and the search engine.
// Depends on pib_pkg.
module pib_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  pib_pkg::pib_item_type push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output pib_pkg::pib_item_type pop_data
);
   import pib_pkg::*;

   pib_item_type                slot_ff [QueueDepth];
   logic [QueuePtrBits-1:0]     wr_ptr_ff;
   logic [QueuePtrBits-1:0]     wr_ptr_in;
   logic [QueuePtrBits-1:0]     rd_ptr_ff;
   logic [QueuePtrBits-1:0]     rd_ptr_in;
   logic [QueueFillBits-1:0]    fill_ff;
   logic [QueueFillBits-1:0]    fill_in;
   logic                        do_push;
   logic                        do_pop;

   assign push_ready = fill_ff != QueueFillBits'(QueueDepth);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/pib_search.sv =====
`timescale 1ns / 1ps
// Search engine: scans the palette memory one entry per cycle, appends
// unmatched colors and drives the result register. Depends on pib_pkg.
module pib_search #(
   parameter int PALETTE_DEPTH = 256,
   parameter int PIXEL_BITS    = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  pib_pkg::pib_item_type pop_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pib_pkg::pib_rsp_type  rsp_data
);
   import pib_pkg::*;

   localparam int StoreBits = (PIXEL_BITS < ColorWidth) ? PIXEL_BITS : ColorWidth;
   localparam int AddrBits  = $clog2(PALETTE_DEPTH);
   localparam int CountBits = $clog2(PALETTE_DEPTH + 1);
   localparam logic [CountBits-1:0] DepthCount = CountBits'(PALETTE_DEPTH);

   logic [StoreBits-1:0] palette_mem [PALETTE_DEPTH];

   pib_state_type        state_ff;
   pib_state_type        state_in;
   logic [StoreBits-1:0] color_ff;
   logic                 last_ff;
   logic [CountBits-1:0] count_ff;
   logic [CountBits-1:0] count_in;
   logic [CountBits-1:0] issue_cnt_ff;
   logic [CountBits-1:0] issue_cnt_in;
   logic                 cmp_valid_ff;
   logic [AddrBits-1:0]  cmp_idx_ff;
   logic [StoreBits-1:0] rd_data_ff;
   pib_rsp_type          res_ff;
   pib_rsp_type          res_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   pib_rsp_type          rsp_data_ff;

   logic                 take;
   logic                 issue;
   logic                 match;
   logic                 miss;
   logic                 store;
   logic                 load_out;
   logic                 out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pop_ready = take;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match || miss) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath controls.
   always_comb begin
      take     = 1'b0;
      issue    = 1'b0;
      match    = 1'b0;
      miss     = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            take = pop_valid;
         end
         ST_SCAN: begin
            match = cmp_valid_ff && (rd_data_ff == color_ff);
            issue = !match && (issue_cnt_ff < count_ff);
            miss  = !match && !cmp_valid_ff && !(issue_cnt_ff < count_ff);
         end
         ST_HOLD: begin
            load_out = out_free;
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

   assign store = miss && (count_ff < DepthCount);

   always_comb begin
      res_in   = res_ff;
      count_in = count_ff;
      if (match || miss) begin
         res_in.image_done       = last_ff;
         res_in.is_new_color     = store;
         res_in.palette_overflow = miss && !store;
         if (match) begin
            res_in.color_index = IndexWidth'(cmp_idx_ff);
            res_in.color_count = CountWidth'(count_ff);
            count_in           = count_ff;
         end else if (store) begin
            res_in.color_index = IndexWidth'(count_ff);
            res_in.color_count = CountWidth'(count_ff + 1'b1);
            count_in           = count_ff + 1'b1;
         end else begin
            res_in.color_index = '0;
            res_in.color_count = CountWidth'(count_ff);
            count_in           = count_ff;
         end
         // End of image: the palette restarts empty for the next pixel.
         if (last_ff) begin
            count_in = '0;
         end
      end
   end

   always_comb begin
      issue_cnt_in = issue_cnt_ff;
      if (take) begin
         issue_cnt_in = '0;
      end else if (issue) begin
         issue_cnt_in = issue_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_cnt_ff <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_cnt_ff <= issue_cnt_in;
         cmp_valid_ff <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         color_ff <= pop_data.color[StoreBits-1:0];
         last_ff  <= pop_data.last;
      end
      cmp_idx_ff <= issue_cnt_ff[AddrBits-1:0];
      res_ff     <= res_in;
      if (load_out) begin
         rsp_data_ff <= res_ff;
      end
   end

   // Palette memory: one read port for the scan, one write port for appends.
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= palette_mem[issue_cnt_ff[AddrBits-1:0]];
      end
      if (store) begin
         palette_mem[count_ff[AddrBits-1:0]] <= color_ff;
      end
   end

endmodule

// ===== sv/palette_index_builder_core.sv =====
`timescale 1ns / 1ps
// Top level of the palette index builder: front stage, item queue and
// search engine. Depends on pib_pkg, pib_front, pib_queue and pib_search.
//
// Each pixel is looked up in a palette of the colors seen so far in the
// current image, in order of arrival, and answered with the index of the
// first match, or appended as a new entry, or flagged as overflow when the
// palette is full. The palette memory has one read port and the search reads
// one entry per cycle, so a hit at index k is found only after entries 0 to
// k are read and a miss only after all n stored entries are read; a pixel
// also holds the search engine while its result waits for the result
// register to free. A two-entry queue in front of the search lets up to three
// further pixels be accepted while one is searched, and a finished result
// waits in its own register without stalling the next search. A pixel with
// last_pixel set closes the image; the next pixel starts an empty palette.
// The palette memory needs no clearing after reset.
module palette_index_builder_core #(
   parameter int PALETTE_DEPTH = 256,
   parameter int PIXEL_BITS    = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pib_pkg::pib_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pib_pkg::pib_rsp_type rsp_data
);
   import pib_pkg::*;

   logic         push_valid;
   logic         push_ready;
   pib_item_type push_data;
   logic         pop_valid;
   logic         pop_ready;
   pib_item_type pop_data;

   pib_front #(
      .PIXEL_BITS(PIXEL_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   pib_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pib_search #(
      .PALETTE_DEPTH(PALETTE_DEPTH),
      .PIXEL_BITS   (PIXEL_BITS)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/pib_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the palette index builder results.
// Depends on pib_pkg; bound to palette_index_builder_core below.
module pib_checker #(
   parameter int PALETTE_DEPTH = 256
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input pib_pkg::pib_rsp_type rsp_data
);
   import pib_pkg::*;

   localparam logic [CountWidth-1:0] DepthCount = CountWidth'(PALETTE_DEPTH);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_overflow_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.palette_overflow |->
         rsp_data.color_index == '0 && !rsp_data.is_new_color &&
         rsp_data.color_count == DepthCount)
      else $error("overflow result malformed");

   a_new_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_new_color |->
         rsp_data.color_count == CountWidth'(rsp_data.color_index) + 1'b1)
      else $error("new color not at end of palette");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.palette_overflow |->
         CountWidth'(rsp_data.color_index) < rsp_data.color_count &&
         rsp_data.color_count <= DepthCount)
      else $error("index outside palette");

endmodule

bind palette_index_builder_core pib_checker #(
   .PALETTE_DEPTH(PALETTE_DEPTH)
) u_pib_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== test/palette_index_builder_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for palette_index_builder_core: drives pixel items, predicts
// each palette lookup in step with the block and compares every result item.
// Depends on pib_pkg and the RTL of palette_index_builder_core.
module palette_index_builder_core_tb;
   import pib_pkg::*;

   localparam int PaletteDepth = 256;
   localparam int PixelBits    = 32;
   localparam int CycleLimit   = 1_000_000;
   localparam int DrainCycles  = 300;
   localparam int HoldCycles   = 200;
   localparam int HoldAtResult = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   pib_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   pib_rsp_type rsp_data;

   palette_index_builder_core #(
      .PALETTE_DEPTH(PaletteDepth),
      .PIXEL_BITS   (PixelBits)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   pib_req_type           pixel_queue[$];
   pib_rsp_type           expected_lookups[$];
   logic [ColorWidth-1:0] palette_colors[PaletteDepth];
   int                    palette_fill = 0;
   int                    send_idle_pct = 0;
   int                    stall_pct = 0;
   int                    results_seen = 0;
   int                    failures = 0;
   int                    cycle_count = 0;
   int                    hold_left = 0;
   bit                    hold_taken = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Palette lookup as the block does it: first match in arrival order,
   // else append, else overflow; a last pixel empties the palette afterward.
   function automatic pib_rsp_type lookup_pixel(pib_req_type px);
      pib_rsp_type           r;
      logic [ColorWidth-1:0] color;
      int                    fill;
      bit                    hit;
      r = '0;
      hit = 1'b0;
      fill = palette_fill;
      color = px.pixel_color & ColorWidth'((64'd1 << PixelBits) - 64'd1);
      for (int k = 0; k < fill && !hit; k++) begin
         if (palette_colors[k] == color) begin
            hit = 1'b1;
            r.color_index = k[IndexWidth-1:0];
         end
      end
      if (!hit) begin
         if (fill < PaletteDepth) begin
            palette_colors[fill] = color;
            r.color_index = fill[IndexWidth-1:0];
            r.is_new_color = 1'b1;
            fill++;
         end else begin
            r.palette_overflow = 1'b1;
         end
      end
      r.color_count = fill[CountWidth-1:0];
      r.image_done = px.last_pixel;
      palette_fill = px.last_pixel ? 0 : fill;
      return r;
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   task automatic push_pixel(logic [ColorWidth-1:0] color, logic last);
      pib_req_type px;
      px.pixel_color = color;
      px.last_pixel = last;
      pixel_queue.push_back(px);
   endtask

   // One image drawn from a small pool of colors, some of them one bit
   // away from another pool color so that near misses are searched.
   task automatic add_image(int len, int pool_n);
      logic [ColorWidth-1:0] pool[$];
      logic [ColorWidth-1:0] c;
      for (int i = 0; i < pool_n; i++) begin
         if (i > 0 && $urandom_range(3) == 0)
            c = pool[i-1] ^ (32'd1 << $urandom_range(ColorWidth-1));
         else
            c = $urandom;
         pool.push_back(c);
      end
      for (int i = 0; i < len; i++)
         push_pixel(pool[$urandom_range(pool_n-1)], i == len - 1);
   endtask

   task automatic add_small_images(int total);
      int added;
      int len;
      added = 0;
      while (added < total) begin
         len = $urandom_range(1, 40);
         add_image(len, $urandom_range(1, 16));
         added += len;
      end
   endtask

   // Fill the palette completely, with hits along the way, then drive it
   // into overflow and end the image on an overflowing pixel.
   task automatic add_overflow_image();
      logic [ColorWidth-1:0] base;
      base = $urandom;
      for (int i = 0; i < PaletteDepth; i++) begin
         push_pixel(base + i, 1'b0);
         if (i % 32 == 31)
            push_pixel(base + $urandom_range(i), 1'b0);
      end
      for (int i = 0; i < 6; i++)
         push_pixel(base + PaletteDepth + i, 1'b0);
      push_pixel(base + PaletteDepth - 1, 1'b0);
      push_pixel(base, 1'b0);
      push_pixel(base + 128, 1'b0);
      push_pixel(base + PaletteDepth, 1'b0);
      push_pixel(base + 999, 1'b1);
   endtask

   task automatic add_directed();
      push_pixel(32'h0000_0000, 1'b0);
      push_pixel(32'hFFFF_FFFF, 1'b0);
      push_pixel(32'h0000_0000, 1'b0);
      push_pixel(32'hFFFF_FFFF, 1'b1);
      // single-pixel image right after an end of image
      push_pixel(32'hFFFF_FFFF, 1'b1);
      push_pixel(32'h8000_0000, 1'b0);
      push_pixel(32'h0000_0001, 1'b0);
      push_pixel(32'h8000_0001, 1'b0);
      push_pixel(32'h8000_0000, 1'b0);
      push_pixel(32'h0000_0001, 1'b1);
      push_pixel(32'hA5A5_A5A5, 1'b0);
      push_pixel(32'h5A5A_5A5A, 1'b0);
      push_pixel(32'hA5A5_A5A4, 1'b0);
      push_pixel(32'h5A5A_5A5A, 1'b1);
   endtask

   // Wait until every item has been offered, accepted and answered.
   task automatic drain();
      while (pixel_queue.size() != 0 || expected_lookups.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   // Sender: offer the head of the pixel queue, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            void'(pixel_queue.pop_front());
         if (!req_valid || req_ready) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pixel_queue[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off to back the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_taken && results_seen == HoldAtResult) begin
         hold_taken <= 1'b1;
         hold_left <= HoldCycles;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Monitor: predict on every accepted pixel, check every accepted result.
   always @(posedge clock) begin
      pib_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_lookups.push_back(lookup_pixel(req_data));
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (expected_lookups.size() == 0) begin
               $error("result item with no pixel pending");
               failures++;
            end else begin
               want = expected_lookups.pop_front();
               compare_field("color_index", int'(want.color_index),
                             int'(rsp_data.color_index));
               compare_field("is_new_color", int'(want.is_new_color),
                             int'(rsp_data.is_new_color));
               compare_field("palette_overflow", int'(want.palette_overflow),
                             int'(rsp_data.palette_overflow));
               compare_field("color_count", int'(want.color_count),
                             int'(rsp_data.color_count));
               compare_field("image_done", int'(want.image_done),
                             int'(rsp_data.image_done));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // no random idling on either side
      send_idle_pct = 0;
      stall_pct = 0;
      add_directed();
      add_small_images(80);
      add_overflow_image();
      drain();

      send_idle_pct = 59;
      stall_pct = 0;
      add_small_images(130);
      drain();

      send_idle_pct = 0;
      stall_pct = 59;
      add_small_images(130);
      drain();

      send_idle_pct = 29;
      stall_pct = 29;
      add_small_images(130);
      drain();

      repeat (DrainCycles) @(posedge clock);
      if (failures == 0 && expected_lookups.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/pib_pkg.sv
sv/pib_front.sv
sv/pib_queue.sv
sv/pib_search.sv
sv/palette_index_builder_core.sv
sv/pib_checker.sv
test/palette_index_builder_core_tb.sv
